// ===== hw/rtl/sil_pkg.sv =====
// Shared types and codes for the sorted insertion list.
package sil_pkg;

  localparam int unsigned VALUE_W = 32;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DUMP   = 1'b1;

  localparam logic [1:0] STATUS_INSERTED = 2'd0;
  localparam logic [1:0] STATUS_DROPPED  = 2'd1;
  localparam logic [1:0] STATUS_ELEMENT  = 2'd2;
  localparam logic [1:0] STATUS_EMPTY    = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic                       valid;
    logic                       gt;
    logic signed [VALUE_W-1:0]  data;
  } cell_link_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic                       insert;
    logic                       rotate;
    logic signed [VALUE_W-1:0]  value;
  } cell_op_t;

endpackage

// ===== hw/rtl/sil_cell.sv =====
// One cell of the sorted chain: a stored value, its occupied flag and the shift rules.
module sil_cell (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  sil_pkg::cell_op_t                      op,
  input  sil_pkg::cell_link_t                    left,
  input  sil_pkg::cell_link_t                    right,
  input  logic signed [sil_pkg::VALUE_W-1:0]     head,
  output sil_pkg::cell_link_t                    link
);

  logic                                valid_r, valid_nxt;
  logic signed [sil_pkg::VALUE_W-1:0]  data_r, data_nxt;
  logic                                gt;

  assign gt = valid_r && (data_r > op.value);

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (op.insert) begin
      // A larger or empty cell takes its left neighbor's value if that one moves
      // too, otherwise it becomes the slot for the new value.
      if ((gt || !valid_r) && left.valid) begin
        data_nxt  = left.gt ? left.data : op.value;
        valid_nxt = 1'b1;
      end
    end else if (op.rotate) begin
      // Values move toward the head; the head value wraps to the tail.
      if (right.valid) begin
        data_nxt = right.data;
      end else if (valid_r) begin
        data_nxt = head;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

  assign link.valid = valid_r;
  assign link.gt    = gt;
  assign link.data  = data_r;

endmodule

// ===== hw/rtl/sorted_insert_list.sv =====
// Insert: one request per cycle if the output is free, result registered on acceptance.
// Dump of n values: n results, one per cycle unless stalled, the chain rotating once per
// result; no request is taken meanwhile. Empty dump or full insert: one result.
// Throughput is set by the single output register and the rotating cell chain.
// Reset clears the entry count, every cell's occupied flag and the output valid.
module sorted_insert_list #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_cmd,
  input  logic signed [sil_pkg::VALUE_W-1:0]   in_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [sil_pkg::VALUE_W-1:0]   out_value,
  output logic                                 out_last,
  output logic [1:0]                           out_status
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  sil_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]                       count_r, count_nxt;
  logic [CW-1:0]                       rem_r, rem_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic signed [sil_pkg::VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic                                out_last_r, out_last_nxt;
  logic [1:0]                          out_status_r, out_status_nxt;

  logic                                out_free;
  logic                                accept;
  logic                                full;
  sil_pkg::cell_op_t                   op;
  sil_pkg::cell_link_t                 links [DEPTH];

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == sil_pkg::ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign full     = links[DEPTH-1].valid;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sil_pkg::ST_IDLE: begin
        if (accept && (in_cmd == sil_pkg::CMD_DUMP) && (count_r != '0)) begin
          state_nxt = sil_pkg::ST_DUMP;
        end
      end
      sil_pkg::ST_DUMP: begin
        if (out_free && (rem_r == CW'(1))) begin
          state_nxt = sil_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sil_pkg::ST_IDLE;
    endcase
  end

  // Outputs, chain operation and counters.
  always_comb begin
    count_nxt      = count_r;
    rem_nxt        = rem_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    op.insert      = 1'b0;
    op.rotate      = 1'b0;
    op.value       = in_value;
    case (state_r)
      sil_pkg::ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          out_last_nxt  = 1'b1;
          if (in_cmd == sil_pkg::CMD_INSERT) begin
            if (full) begin
              out_status_nxt = sil_pkg::STATUS_DROPPED;
            end else begin
              out_status_nxt = sil_pkg::STATUS_INSERTED;
              op.insert      = 1'b1;
              count_nxt      = count_r + CW'(1);
            end
          end else if (count_r == '0) begin
            out_status_nxt = sil_pkg::STATUS_EMPTY;
          end else begin
            // The dump results come from the following cycles.
            out_valid_nxt = 1'b0;
            rem_nxt       = count_r;
          end
        end
      end
      sil_pkg::ST_DUMP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = links[0].data;
          out_last_nxt   = (rem_r == CW'(1));
          out_status_nxt = sil_pkg::STATUS_ELEMENT;
          op.rotate      = 1'b1;
          rem_nxt        = rem_r - CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sil_pkg::ST_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sil_pkg::cell_link_t left_lnk;
    sil_pkg::cell_link_t right_lnk;

    if (i == 0) begin : g_head
      assign left_lnk = '{valid: 1'b1, gt: 1'b0, data: '0};
    end else begin : g_mid
      assign left_lnk = links[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_lnk = '{valid: 1'b0, gt: 1'b0, data: '0};
    end else begin : g_body
      assign right_lnk = links[i+1];
    end

    sil_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .op    (op),
      .left  (left_lnk),
      .right (right_lnk),
      .head  (links[0].data),
      .link  (links[i])
    );
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Testbench for sorted_insert_list: checks insert and dump requests against an ordered-table predictor.
module tb;

  localparam int unsigned LIST_DEPTH       = 16;
  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned RANDOM_PER_PHASE = 43;
  localparam int unsigned DUMP_PCT         = 30;
  localparam int unsigned DRAIN_CYCLES     = 20;

  localparam logic signed [sil_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [sil_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic signed [sil_pkg::VALUE_W-1:0] value;
    logic                               last;
    logic [1:0]                         status;
  } list_result_t;

  class list_scoreboard;
    logic signed [sil_pkg::VALUE_W-1:0] entries [LIST_DEPTH];
    int unsigned                        count;
    list_result_t                       expected_q [$];
    int unsigned                        errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function void push_result(logic signed [sil_pkg::VALUE_W-1:0] v, logic last,
                              logic [1:0] st);
      list_result_t r;
      r.value  = v;
      r.last   = last;
      r.status = st;
      expected_q.push_back(r);
    endfunction

    // Predicts the results of one accepted request and updates the ordered table.
    function void note_request(logic cmd, logic signed [sil_pkg::VALUE_W-1:0] v);
      int unsigned pos;
      int unsigned i;
      if (cmd == sil_pkg::CMD_INSERT) begin
        if (count >= LIST_DEPTH) begin
          push_result('0, 1'b1, sil_pkg::STATUS_DROPPED);
        end else begin
          // Equal values go after the stored ones, so arrival order is kept.
          pos = 0;
          while (pos < count && entries[pos] <= v) pos++;
          for (i = count; i > pos; i--) entries[i] = entries[i-1];
          entries[pos] = v;
          count++;
          push_result('0, 1'b1, sil_pkg::STATUS_INSERTED);
        end
      end else if (count == 0) begin
        push_result('0, 1'b1, sil_pkg::STATUS_EMPTY);
      end else begin
        for (i = 0; i < count; i++)
          push_result(entries[i], (i + 1 == count), sil_pkg::STATUS_ELEMENT);
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic signed [sil_pkg::VALUE_W-1:0] v, logic last, logic [1:0] st);
      list_result_t w;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result value %0d last %0d code %0d", v, last, st));
        return;
      end
      w = expected_q.pop_front();
      if (v !== w.value)
        report($sformatf("out_value got %0d want %0d", v, w.value));
      if (last !== w.last)
        report($sformatf("out_last got %0d want %0d", last, w.last));
      if (st !== w.status)
        report($sformatf("out_status got %0d want %0d", st, w.status));
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                               clk;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_ready;
  logic                               in_cmd;
  logic signed [sil_pkg::VALUE_W-1:0] in_value;
  logic                               out_valid;
  logic                               out_ready;
  logic signed [sil_pkg::VALUE_W-1:0] out_value;
  logic                               out_last;
  logic [1:0]                         out_status;

  int unsigned    send_idle_pct;
  int unsigned    stall_pct;
  int unsigned    cycles;
  list_scoreboard sb;

  sorted_insert_list #(
    .DEPTH(LIST_DEPTH)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .out_last   (out_last),
    .out_status (out_status)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_value, out_last, out_status);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Called right after a rising edge; returns at the edge that accepts the request.
  task send_request(input logic cmd, input logic signed [sil_pkg::VALUE_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_request(cmd, v);
  endtask

  function logic signed [sil_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(4))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return $signed($urandom_range(16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic cmd;
    sb            = new();
    cycles        = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_cmd        = sil_pkg::CMD_INSERT;
    in_value      = '0;
    out_ready     = 1'b0;
    send_idle_pct = 8;
    stall_pct     = 54;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty dump, extremes and duplicates, a partial dump, then fill up and overflow.
    send_request(sil_pkg::CMD_DUMP, $urandom);
    send_request(sil_pkg::CMD_INSERT, 0);
    send_request(sil_pkg::CMD_INSERT, VAL_MAX);
    send_request(sil_pkg::CMD_INSERT, VAL_MIN);
    send_request(sil_pkg::CMD_INSERT, -1);
    send_request(sil_pkg::CMD_INSERT, 1);
    send_request(sil_pkg::CMD_INSERT, 0);
    send_request(sil_pkg::CMD_INSERT, VAL_MAX);
    send_request(sil_pkg::CMD_DUMP, $urandom);
    send_request(sil_pkg::CMD_INSERT, 32'sh5555_5555);
    send_request(sil_pkg::CMD_INSERT, 32'shAAAA_AAAA);
    send_request(sil_pkg::CMD_INSERT, -2);
    send_request(sil_pkg::CMD_INSERT, 2);
    send_request(sil_pkg::CMD_INSERT, VAL_MIN);
    send_request(sil_pkg::CMD_INSERT, 100);
    send_request(sil_pkg::CMD_INSERT, -100);
    send_request(sil_pkg::CMD_INSERT, 7);
    send_request(sil_pkg::CMD_INSERT, -7);
    send_request(sil_pkg::CMD_DUMP, $urandom);
    send_request(sil_pkg::CMD_INSERT, VAL_MIN);
    send_request(sil_pkg::CMD_INSERT, VAL_MAX);
    send_request(sil_pkg::CMD_DUMP, $urandom);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 8;
          stall_pct     = 54;
        end
        1: begin
          send_idle_pct = 54;
          stall_pct     = 8;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        cmd = ($urandom_range(99) < DUMP_PCT) ? sil_pkg::CMD_DUMP : sil_pkg::CMD_INSERT;
        send_request(cmd, pick_value());
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sil_pkg.sv
hw/rtl/sil_cell.sv
hw/rtl/sorted_insert_list.sv
sim/tb.sv
